### sv/sqe_pkg.sv
package sqe_pkg;

  // Store geometry
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // Command codes
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_POP  = 3'd1;
  localparam logic [2:0] CMD_SWAP = 3'd2;
  localparam logic [2:0] CMD_PEEK = 3'd3;
  localparam logic [2:0] CMD_DUMP = 3'd4;

  // Status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_SHORT = 2'd2;
  localparam logic [1:0] STS_FULL  = 2'd3;

  // Where a cell takes its next word from
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_ABOVE,
    SEL_BELOW,
    SEL_TOP
  } cell_sel_e;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Low VALUE_WIDTH bits of the sign-extended input word
  function automatic word_t to_word(logic [31:0] v);
    logic [95:0] ext;
    ext = {{64{v[31]}}, v};
    return ext[VALUE_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word and cut it to 32 bits
  function automatic logic [31:0] out_word(word_t w);
    logic [VALUE_WIDTH+63:0] ext;
    ext = {{64{w[VALUE_WIDTH-1]}}, w};
    return ext[31:0];
  endfunction

endpackage

### sv/sqe_cell.sv
module sqe_cell (
  input  logic                clk_i,
  input  sqe_pkg::cell_sel_e  sel_i,
  input  sqe_pkg::word_t      new_i,
  input  sqe_pkg::word_t      above_i,
  input  sqe_pkg::word_t      below_i,
  input  sqe_pkg::word_t      top_i,
  output sqe_pkg::word_t      data_o
);

  sqe_pkg::word_t data_q, data_d;

  // Pick the next word from a neighbor, the new value or the top of the row
  always_comb begin
    case (sel_i)
      sqe_pkg::SEL_NEW:   data_d = new_i;
      sqe_pkg::SEL_ABOVE: data_d = above_i;
      sqe_pkg::SEL_BELOW: data_d = below_i;
      sqe_pkg::SEL_TOP:   data_d = top_i;
      default:            data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### sv/stack_queue_engine.sv
// Timing: push, pop, swap, peek and error results appear in the cycle after the
// input transaction; a dump enters its dump state, then registers its words.
// Throughput: one transaction per cycle for single-result commands unless the
// output stalls; a dump holds off the input until all N stored entries are out.
// Reset (rst_ni low, async): store empty, stack mode, no result pending;
// the entry words themselves are not cleared.
module stack_queue_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sqe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sqe_pkg::out_item_t out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                         state_q, state_d;
  logic                         queue_mode_q;
  logic [sqe_pkg::CNT_W-1:0]    count_q, count_d;
  logic [sqe_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [sqe_pkg::CNT_W-1:0]    cnt_m1;
  logic                         out_valid_q, out_valid_d;
  sqe_pkg::out_item_t           out_q, out_d;

  logic                         out_free, in_acc;
  logic                         do_push_stack, do_push_queue, do_pop, do_swap, do_rot;
  sqe_pkg::word_t               new_word;
  sqe_pkg::word_t               cell_data [sqe_pkg::DEPTH];
  sqe_pkg::cell_sel_e           cell_sel  [sqe_pkg::DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign new_word   = sqe_pkg::to_word(in_data_i.push_value);
  assign cnt_m1     = count_q - sqe_pkg::CNT_W'(1);

  // Command decode, result and sequencing
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rem_d         = rem_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    do_push_stack = 1'b0;
    do_push_queue = 1'b0;
    do_pop        = 1'b0;
    do_swap       = 1'b0;
    do_rot        = 1'b0;

    if (in_acc) begin
      out_valid_d      = 1'b1;
      out_d.item_value = '0;
      out_d.status     = sqe_pkg::STS_OK;
      out_d.last       = 1'b1;
      case (in_data_i.command)
        sqe_pkg::CMD_PUSH: begin
          if (count_q == sqe_pkg::CNT_W'(sqe_pkg::DEPTH)) begin
            out_d.status = sqe_pkg::STS_FULL;
          end else begin
            do_push_stack = !queue_mode_q;
            do_push_queue = queue_mode_q;
            count_d       = count_q + sqe_pkg::CNT_W'(1);
          end
        end
        sqe_pkg::CMD_POP: begin
          if (count_q == '0) begin
            out_d.status = sqe_pkg::STS_EMPTY;
          end else begin
            do_pop  = 1'b1;
            count_d = cnt_m1;
          end
        end
        sqe_pkg::CMD_SWAP: begin
          if (count_q < sqe_pkg::CNT_W'(2)) begin
            out_d.status = sqe_pkg::STS_SHORT;
          end else begin
            do_swap = 1'b1;
          end
        end
        sqe_pkg::CMD_PEEK: begin
          if (count_q == '0) begin
            out_d.status = sqe_pkg::STS_EMPTY;
          end else begin
            out_d.item_value = sqe_pkg::out_word(cell_data[0]);
          end
        end
        sqe_pkg::CMD_DUMP: begin
          if (count_q == '0) begin
            out_d.status = sqe_pkg::STS_EMPTY;
          end else begin
            // words come out of the dump walk instead
            out_valid_d = 1'b0;
            out_d       = out_q;
            rem_d       = count_q;
            state_d     = ST_DUMP;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_DUMP && out_free) begin
      // emit the top word and rotate the occupied cells by one
      out_valid_d      = 1'b1;
      out_d.item_value = sqe_pkg::out_word(cell_data[0]);
      out_d.status     = sqe_pkg::STS_OK;
      out_d.last       = (rem_q == sqe_pkg::CNT_W'(1));
      do_rot           = 1'b1;
      rem_d            = rem_q - sqe_pkg::CNT_W'(1);
      if (rem_q == sqe_pkg::CNT_W'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Row of storage cells, cell 0 is the top
  for (genvar i = 0; i < sqe_pkg::DEPTH; i++) begin : g_cell
    localparam logic [sqe_pkg::CNT_W-1:0] IDX = sqe_pkg::CNT_W'(i);
    sqe_pkg::word_t above_w, below_w;

    if (i == 0) begin : g_first
      assign above_w = '0;
    end else begin : g_mid_a
      assign above_w = cell_data[i-1];
    end
    if (i == sqe_pkg::DEPTH - 1) begin : g_last
      assign below_w = '0;
    end else begin : g_mid_b
      assign below_w = cell_data[i+1];
    end

    always_comb begin
      cell_sel[i] = sqe_pkg::SEL_HOLD;
      if (do_push_stack) begin
        cell_sel[i] = (i == 0) ? sqe_pkg::SEL_NEW : sqe_pkg::SEL_ABOVE;
      end else if (do_push_queue) begin
        if (IDX == count_q) cell_sel[i] = sqe_pkg::SEL_NEW;
      end else if (do_pop) begin
        cell_sel[i] = sqe_pkg::SEL_BELOW;
      end else if (do_swap) begin
        if (i == 0) cell_sel[i] = sqe_pkg::SEL_BELOW;
        if (i == 1) cell_sel[i] = sqe_pkg::SEL_ABOVE;
      end else if (do_rot) begin
        if (IDX == cnt_m1) begin
          cell_sel[i] = sqe_pkg::SEL_TOP;
        end else if (IDX < cnt_m1) begin
          cell_sel[i] = sqe_pkg::SEL_BELOW;
        end
      end
    end

    sqe_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel[i]),
      .new_i   (new_word),
      .above_i (above_w),
      .below_i (below_w),
      .top_i   (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      queue_mode_q <= 1'b0;
      count_q      <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        queue_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sqe_pkg::CNT_W'(sqe_pkg::DEPTH))
    else $error("entry count above depth");

  a_dump_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> rem_q != '0 && rem_q <= count_q)
    else $error("dump walk count out of range");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.command != sqe_pkg::CMD_DUMP |=> out_valid_q && out_q.last)
    else $error("single result missing");

  a_not_last_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> state_q == ST_DUMP)
    else $error("non-final result outside dump");
`endif

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Commands outside the defined set; the engine answers them with ok and no change
  localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  sqe_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  sqe_pkg::out_item_t out_data_o;

  stack_queue_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Mirror of the store: circular buffer with a top index
  sqe_pkg::word_t stored_words [sqe_pkg::DEPTH];
  int unsigned    top_idx;
  int unsigned    word_count;
  bit             queue_mode_q;

  sqe_pkg::out_item_t pending_results [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned dumps_sent;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  bit          full_speed;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 12);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_command(int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(99) < push_pct) return sqe_pkg::CMD_PUSH;
    r = $urandom_range(99);
    if (r < 40) return sqe_pkg::CMD_POP;
    if (r < 60) return sqe_pkg::CMD_SWAP;
    if (r < 80) return sqe_pkg::CMD_PEEK;
    if (r < 92) return sqe_pkg::CMD_DUMP;
    return 3'($urandom_range(CMD_UNKNOWN_LAST, CMD_UNKNOWN_FIRST));
  endfunction

  task automatic note_failure(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Stored word, sign-extended from the word width and cut to 32 bits
  function automatic logic [31:0] read_word(int unsigned idx);
    sqe_pkg::word_t                   w;
    logic [sqe_pkg::VALUE_WIDTH+63:0] wide;
    w    = stored_words[idx];
    wide = {{64{w[sqe_pkg::VALUE_WIDTH-1]}}, w};
    return wide[31:0];
  endfunction

  // Update the mirror for one accepted command and queue the results it owes
  function automatic void predict_results(sqe_pkg::in_item_t item);
    sqe_pkg::out_item_t res;
    logic [95:0]        wide;
    sqe_pkg::word_t     w;
    int unsigned        p;
    res.item_value = '0;
    res.status     = sqe_pkg::STS_OK;
    res.last       = 1'b1;
    case (item.command)
      sqe_pkg::CMD_PUSH: begin
        if (word_count >= sqe_pkg::DEPTH) begin
          res.status = sqe_pkg::STS_FULL;
        end else begin
          wide = {{64{item.push_value[31]}}, item.push_value};
          w    = wide[sqe_pkg::VALUE_WIDTH-1:0];
          if (!queue_mode_q) begin
            if (word_count != 0) top_idx = (top_idx + 1) % sqe_pkg::DEPTH;
            stored_words[top_idx] = w;
          end else begin
            // bottom slot sits word_count below the top
            p = (top_idx + sqe_pkg::DEPTH - word_count) % sqe_pkg::DEPTH;
            stored_words[p] = w;
          end
          word_count++;
        end
        pending_results.push_back(res);
      end
      sqe_pkg::CMD_POP: begin
        if (word_count == 0) begin
          res.status = sqe_pkg::STS_EMPTY;
        end else begin
          word_count--;
          if (word_count != 0) top_idx = (top_idx + sqe_pkg::DEPTH - 1) % sqe_pkg::DEPTH;
        end
        pending_results.push_back(res);
      end
      sqe_pkg::CMD_SWAP: begin
        if (word_count < 2) begin
          res.status = sqe_pkg::STS_SHORT;
        end else begin
          p = (top_idx + sqe_pkg::DEPTH - 1) % sqe_pkg::DEPTH;
          w = stored_words[top_idx];
          stored_words[top_idx] = stored_words[p];
          stored_words[p] = w;
        end
        pending_results.push_back(res);
      end
      sqe_pkg::CMD_PEEK: begin
        if (word_count == 0) res.status = sqe_pkg::STS_EMPTY;
        else res.item_value = read_word(top_idx);
        pending_results.push_back(res);
      end
      sqe_pkg::CMD_DUMP: begin
        if (word_count == 0) begin
          res.status = sqe_pkg::STS_EMPTY;
          pending_results.push_back(res);
        end else begin
          p = top_idx;
          for (int i = 0; i < int'(word_count); i++) begin
            res.item_value = read_word(p);
            res.last       = (i + 1 == int'(word_count));
            pending_results.push_back(res);
            p = (p + sqe_pkg::DEPTH - 1) % sqe_pkg::DEPTH;
          end
        end
      end
      default: pending_results.push_back(res);
    endcase
  endfunction

  // Offer one command and wait for the transaction
  task automatic send_item(logic [2:0] command, logic [31:0] value);
    sqe_pkg::in_item_t item;
    int unsigned       gap;
    item.command    = command;
    item.push_value = value;
    gap = full_speed ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_results(item);
    items_sent++;
    if (command == sqe_pkg::CMD_DUMP) dumps_sent++;
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(bit mode);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    queue_mode_q = mode;
  endtask

  // Pop, peek, swap and dump against an empty store, plus the undefined codes
  task automatic test_empty_store();
    send_item(sqe_pkg::CMD_POP,  32'h0000_0000);
    send_item(sqe_pkg::CMD_PEEK, 32'hFFFF_FFFF);
    send_item(sqe_pkg::CMD_SWAP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_DUMP, 32'hFFFF_FFFF);
    for (int c = CMD_UNKNOWN_FIRST; c <= CMD_UNKNOWN_LAST; c++) send_item(3'(c), pick_value());
  endtask

  // Stack mode: extreme values, short swap, single-entry dump
  task automatic test_stack_edges();
    send_item(sqe_pkg::CMD_PUSH, 32'h8000_0000);
    send_item(sqe_pkg::CMD_PEEK, 32'h0000_0000);
    send_item(sqe_pkg::CMD_SWAP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_DUMP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_PUSH, 32'h7FFF_FFFF);
    send_item(sqe_pkg::CMD_SWAP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_PEEK, 32'h0000_0000);
    send_item(sqe_pkg::CMD_PUSH, 32'hFFFF_FFFF);
    send_item(sqe_pkg::CMD_PUSH, 32'h0000_0000);
    send_item(sqe_pkg::CMD_PUSH, 32'h5555_5555);
    send_item(sqe_pkg::CMD_PUSH, 32'hAAAA_AAAA);
    send_item(sqe_pkg::CMD_DUMP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_POP,  32'h0000_0000);
  endtask

  // Queue mode: new words land at the bottom, top end unchanged
  task automatic test_queue_order();
    set_mode(1'b1);
    send_item(sqe_pkg::CMD_PUSH, 32'h0000_0001);
    send_item(sqe_pkg::CMD_PUSH, 32'hFFFF_FFFE);
    send_item(sqe_pkg::CMD_PEEK, 32'h0000_0000);
    send_item(sqe_pkg::CMD_DUMP, 32'h0000_0000);
    send_item(sqe_pkg::CMD_POP,  32'h0000_0000);
  endtask

  // Fill to capacity from both ends, overflow in each mode, dump everything
  task automatic test_full_store();
    set_mode(1'b0);
    while (word_count < sqe_pkg::DEPTH / 2) send_item(sqe_pkg::CMD_PUSH, pick_value());
    set_mode(1'b1);
    while (word_count < sqe_pkg::DEPTH) send_item(sqe_pkg::CMD_PUSH, pick_value());
    send_item(sqe_pkg::CMD_PUSH, pick_value());
    set_mode(1'b0);
    send_item(sqe_pkg::CMD_PUSH, pick_value());
    send_item(sqe_pkg::CMD_SWAP, pick_value());
    send_item(sqe_pkg::CMD_DUMP, pick_value());
    send_item(sqe_pkg::CMD_POP,  pick_value());
    send_item(sqe_pkg::CMD_PEEK, pick_value());
  endtask

  task automatic test_random_traffic(bit mode, int unsigned push_pct, int unsigned count,
                                     bit fast);
    set_mode(mode);
    full_speed = fast;
    repeat (count) send_item(pick_command(push_pct), pick_value());
    full_speed = 1'b0;
  endtask

  // Sink side: alternating ready and stall stretches
  always @(posedge clk_i) begin
    if (full_speed) begin
      out_ready_i <= 1'b1;
      ready_hold  <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= ~out_ready_i;
      ready_hold  <= out_ready_i ? pick_gap() : $urandom_range(12, 1);
    end
  end

  // Result checker against the oldest owed result
  always @(posedge clk_i) begin
    sqe_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result value %h status %0d last %0b",
                               out_data_o.item_value, out_data_o.status, out_data_o.last));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data_o.item_value !== want.item_value || out_data_o.status !== want.status ||
            out_data_o.last !== want.last) begin
          note_failure($sformatf(
            "result %0d: expected value %h status %0d last %0b, got value %h status %0d last %0b",
            results_checked, want.item_value, want.status, want.last,
            out_data_o.item_value, out_data_o.status, out_data_o.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    full_speed   = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    results_checked = 0;
    dumps_sent   = 0;
    top_idx      = 0;
    word_count   = 0;
    queue_mode_q = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_mode(1'b0);
    test_empty_store();
    test_stack_edges();
    test_queue_order();
    test_full_store();
    test_random_traffic(1'b1, 30, 28, 1'b0);
    test_random_traffic(1'b0, 45, 28, 1'b1);
    test_random_traffic(1'b1, 70, 28, 1'b0);
    test_random_traffic(1'b0, 60, 28, 1'b0);
    settle();

    $display("ran %0d commands (%0d dumps) in stack and queue mode, checked %0d results",
             items_sent, dumps_sent, results_checked);
    $display("%0d mismatches in %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/sqe_pkg.sv
sv/sqe_cell.sv
sv/stack_queue_engine.sv
dv/testbench.sv
